FILE: rtl/srr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the SipHash round RNG core
// Holds the state word types, the SipHash start constants, the seed tweak
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned NumWords = 4;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [WordW-1:0] srr_word_t;
	typedef logic [NumWords-1:0][WordW-1:0] srr_state_t;
	typedef logic [CfgIdxW-1:0] srr_cfg_idx_t;

	// Request codes.
	localparam logic ReqSeed = 1'b0;
	localparam logic ReqMix  = 1'b1;

	// Configuration register indexes.
	localparam srr_cfg_idx_t CfgKeyLow  = srr_cfg_idx_t'(0);
	localparam srr_cfg_idx_t CfgKeyHigh = srr_cfg_idx_t'(1);

	// SipHash initialization constants and the seed tweak.
	localparam srr_word_t InitC0    = 64'h736f6d6570736575;
	localparam srr_word_t InitC1    = 64'h646f72616e646f6d;
	localparam srr_word_t InitC2    = 64'h6c7967656e657261;
	localparam srr_word_t InitC3    = 64'h7465646279746573;
	localparam srr_word_t SeedTweak = 64'h00000000000000bb;

	// Key held by the configuration registers.
	typedef struct packed {
		srr_word_t lo;
		srr_word_t hi;
	} srr_key_t;

endpackage : srr_pkg
`default_nettype wire

FILE: rtl/srr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ifs: valid/ready channels of the SipHash round RNG core
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface srr_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [srr_pkg::WordW-1:0]   salt;

	modport source (output valid, req_type, salt, input ready);
	modport sink   (input valid, req_type, salt, output ready);
endinterface : srr_req_if

interface srr_res_if;
	logic                        valid;
	logic                        ready;
	logic [srr_pkg::WordW-1:0]   word0;
	logic [srr_pkg::WordW-1:0]   word1;
	logic [srr_pkg::WordW-1:0]   word2;
	logic [srr_pkg::WordW-1:0]   word3;

	modport source (output valid, word0, word1, word2, word3, input ready);
	modport sink   (input valid, word0, word1, word2, word3, output ready);
endinterface : srr_res_if

interface srr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [srr_pkg::CfgIdxW-1:0] index;
	logic [srr_pkg::WordW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface : srr_cfg_if
`default_nettype wire

FILE: rtl/srr_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_cfg: key registers
// Takes configuration write beats and holds the two key words.
// ----------------------------------------------------------------------------
module srr_cfg (
	input  wire              clk,
	input  wire              arst_n,
	srr_cfg_if.sink          cfg,
	output srr_pkg::srr_key_t key
);
	import srr_pkg::*;

	srr_key_t key_q;

	assign cfg.ready = 1'b1;
	assign key       = key_q;

	// Writes to an index with no register behind it are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CfgKeyLow:  key_q.lo <= cfg.data;
				CfgKeyHigh: key_q.hi <= cfg.data;
				default:    ;
			endcase
		end
	end

endmodule : srr_cfg
`default_nettype wire

FILE: rtl/srr_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_round: one SipRound
// Add, rotate and XOR over the four state words, purely combinational.
// ----------------------------------------------------------------------------
module srr_round (
	input  srr_pkg::srr_state_t w_in,
	output srr_pkg::srr_state_t w_out
);
	import srr_pkg::*;

	function automatic srr_word_t rotl(input srr_word_t x, input int unsigned r);
		rotl = (x << r) | (x >> (WordW - r));
	endfunction

	srr_word_t a0, a1, a2, a3;
	srr_word_t b0, b1, b2, b3;

	always_comb begin
		a0 = w_in[0] + w_in[1];
		a1 = rotl(w_in[1], 13) ^ a0;
		a0 = rotl(a0, 32);
		a2 = w_in[2] + w_in[3];
		a3 = rotl(w_in[3], 16) ^ a2;
		b0 = a0 + a3;
		b3 = rotl(a3, 21) ^ b0;
		b2 = a2 + a1;
		b1 = rotl(a1, 17) ^ b2;
		b2 = rotl(b2, 32);
	end

	assign w_out[0] = b0;
	assign w_out[1] = b1;
	assign w_out[2] = b2;
	assign w_out[3] = b3;

endmodule : srr_round
`default_nettype wire

FILE: rtl/srr_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_step: seed or mix step
// Builds the starting words for a seed or a mix and runs four SipRounds,
// with the seed's salt and tweak folded in after the first round.
// ----------------------------------------------------------------------------
module srr_step (
	input  wire                 req_type,
	input  srr_pkg::srr_word_t  salt,
	input  srr_pkg::srr_key_t   key,
	input  srr_pkg::srr_state_t cur,
	output srr_pkg::srr_state_t nxt
);
	import srr_pkg::*;

	srr_state_t start;
	srr_state_t after0;
	srr_state_t stage_in [NumWords];
	srr_state_t stage_out [NumWords];

	always_comb begin
		if (req_type == ReqSeed) begin
			start[0] = InitC0 ^ key.lo;
			start[1] = InitC1 ^ key.hi;
			start[2] = InitC2 ^ key.lo;
			start[3] = InitC3 ^ key.hi ^ salt;
		end else begin
			start[0] = cur[0] ^ key.lo;
			start[1] = cur[1] ^ key.hi;
			start[2] = cur[2] ^ key.lo;
			start[3] = cur[3] ^ key.hi;
		end
	end

	// Between the first and second rounds a seed takes the salt into word 0
	// and the tweak into word 2.
	always_comb begin
		after0 = stage_out[0];
		if (req_type == ReqSeed) begin
			after0[0] = stage_out[0][0] ^ salt;
			after0[2] = stage_out[0][2] ^ SeedTweak;
		end
	end

	genvar g;
	generate
		for (g = 0; g < NumWords; g++) begin : g_round
			if (g == 0) begin : g_first
				assign stage_in[g] = start;
			end else if (g == 1) begin : g_second
				assign stage_in[g] = after0;
			end else begin : g_rest
				assign stage_in[g] = stage_out[g-1];
			end
			srr_round u_round (
				.w_in  (stage_in[g]),
				.w_out (stage_out[g])
			);
		end
	endgenerate

	assign nxt = stage_out[NumWords-1];

endmodule : srr_step
`default_nettype wire

FILE: rtl/siphash_round_rng_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siphash_round_rng_core: keyed random-number core built from SipHash rounds
// Seed and mix requests each run four SipRounds over four 64-bit state
// words and return the new state as one result beat.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat payload                 Notes
//   req      in         req_type, salt               0 = seed, 1 = mix
//   res      out        word0, word1, word2, word3   state after the step
//   cfg      in         index, data                  0 = key_low, 1 = key_high
//
// One request is accepted every cycle while the result side does not stall. A
// request beat lands in the request register; the four-round chain in srr_step
// then writes the state register, which is also the result register, and
// res.valid rises with it. The four chained SipRounds between the request
// register and the state register set the clock period.
// Reset clears the keys, the state words and all valid flags.
// A stalled result holds the state; the request register then fills and
// req.ready falls until the result beat is taken.
//
// The state register doubles as the result register: the next mix reads the
// same words that the result beat shows, so both can never disagree.
// ----------------------------------------------------------------------------
module siphash_round_rng_core (
	input  wire     clk,
	input  wire     arst_n,
	srr_req_if.sink   req,
	srr_res_if.source res,
	srr_cfg_if.sink   cfg
);
	import srr_pkg::*;

	// Key registers; the user must write them only while the core is idle, which the core itself does not enforce.
	srr_key_t key;

	srr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key)
	);

	// Request register.
	logic      req_valid_s1;
	logic      req_type_s1;
	srr_word_t salt_s1;

	// State and result register.
	srr_state_t state_q;
	logic       res_valid_q;
	srr_state_t state_nxt;

	// The result register is free when empty or when its beat leaves now.
	logic res_free;
	logic advance;

	assign res_free  = !res_valid_q || res.ready;
	assign advance   = req_valid_s1 && res_free;
	assign req.ready = !req_valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	// Payload of the request register needs no reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			salt_s1     <= req.salt;
		end
	end

	srr_step u_step (
		.req_type (req_type_s1),
		.salt     (salt_s1),
		.key      (key),
		.cur      (state_q),
		.nxt      (state_nxt)
	);

	// A mix before any seed runs on the all-zero state, so the state resets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (res_free) begin
				res_valid_q <= advance;
			end
		end
	end

	assign res.valid = res_valid_q;
	assign res.word0 = state_q[0];
	assign res.word1 = state_q[1];
	assign res.word2 = state_q[2];
	assign res.word3 = state_q[3];

	// A result beat only appears after a request sat in the request register.
	a_res_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(req_valid_s1))
		else $error("result beat without a pending request");

	// A stalled result must keep the state words, which are its payload and
	// the next mix's input at once.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> $stable(state_q))
		else $error("state changed under a stalled result");

	// A pending request is not dropped while the result side stalls.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && !res_free |=> req_valid_s1 && $stable(salt_s1)
			&& $stable(req_type_s1))
		else $error("pending request lost during stall");

	// Every advance leaves a result beat waiting.
	a_advance_res: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("advanced request produced no result beat");

endmodule : siphash_round_rng_core
`default_nettype wire

FILE: test/siphash_round_rng_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siphash_round_rng_core_tb: self-checking bench of the SipHash round RNG core
// Drives seed and mix requests through the request channel, writes the key
// registers between phases while the core is idle, and checks every result
// beat word by word against a cycle-free prediction of the four-word state.
// ----------------------------------------------------------------------------
module siphash_round_rng_core_tb;

	import srr_pkg::*;

	// Indexes 2 and 3 fit the index field but select no register. Writes to
	// them must leave both key words alone.
	localparam srr_cfg_idx_t CfgSpareA = srr_cfg_idx_t'(2);
	localparam srr_cfg_idx_t CfgSpareB = srr_cfg_idx_t'(3);

	// Quiet cycles to let pass before a key write or the final verdict.
	localparam int unsigned SettleCycles = 6;

	// Watchdog limit, far beyond the slowest legal run.
	localparam int unsigned CycleLimit = 200000;

	// Percentage of cycles in which each side holds back.
	localparam int unsigned IdlePct = 19;

	typedef struct {
		logic      kind;
		srr_word_t salt;
	} rng_req_t;

	logic clk = 1'b0;
	logic arst_n;

	srr_req_if req_ch ();
	srr_res_if res_ch ();
	srr_cfg_if cfg_ch ();

	siphash_round_rng_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting for the driver, and the state words that each accepted
	// request is expected to produce, oldest first.
	rng_req_t   pending_reqs[$];
	srr_state_t expected_states[$];

	// Shadow of the core: its key registers and its four state words.
	srr_key_t   model_key;
	srr_state_t model_state;

	// When set, neither side idles. One whole phase runs this way.
	bit full_rate = 1'b0;

	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	function automatic srr_word_t rotl64(srr_word_t x, int unsigned r);
		return (x << r) | (x >> (WordW - r));
	endfunction

	// One SipRound over the four words: two add-rotate-xor half rounds.
	function automatic srr_state_t sip_round(srr_state_t v);
		v[0] = v[0] + v[1];
		v[1] = rotl64(v[1], 13) ^ v[0];
		v[0] = rotl64(v[0], 32);
		v[2] = v[2] + v[3];
		v[3] = rotl64(v[3], 16) ^ v[2];
		v[0] = v[0] + v[3];
		v[3] = rotl64(v[3], 21) ^ v[0];
		v[2] = v[2] + v[1];
		v[1] = rotl64(v[1], 17) ^ v[2];
		v[2] = rotl64(v[2], 32);
		return v;
	endfunction

	// Steps the shadow state by one request and returns the new words.
	function automatic srr_state_t advance_rng_state(logic kind, srr_word_t salt);
		srr_state_t v;
		if (kind == ReqSeed) begin
			// Seeding starts from the SipHash constants under the key, folds
			// the salt in around the first round and tweaks word 2.
			v[0] = InitC0 ^ model_key.lo;
			v[1] = InitC1 ^ model_key.hi;
			v[2] = InitC2 ^ model_key.lo;
			v[3] = InitC3 ^ model_key.hi ^ salt;
			v = sip_round(v);
			v[0] = v[0] ^ salt;
			v[2] = v[2] ^ SeedTweak;
			repeat (3) v = sip_round(v);
		end else begin
			// Mixing rekeys the current state with the key as it stands now;
			// the salt plays no part.
			v[0] = model_state[0] ^ model_key.lo;
			v[1] = model_state[1] ^ model_key.hi;
			v[2] = model_state[2] ^ model_key.lo;
			v[3] = model_state[3] ^ model_key.hi;
			repeat (4) v = sip_round(v);
		end
		model_state = v;
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic srr_word_t random_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return srr_word_t'(1) << $urandom_range(WordW - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_req(logic kind, srr_word_t salt);
		rng_req_t r;
		r.kind = kind;
		r.salt = salt;
		pending_reqs.push_back(r);
	endtask

	// Most traffic is a seed followed by a run of mixes, which is how the core
	// is used; the rest is loose requests of either kind. Mix beats also carry
	// random salt so that the core is seen to ignore it.
	task automatic queue_random_burst(int unsigned count);
		int unsigned left;
		int unsigned run;
		left = count;
		while (left > 0) begin
			if ($urandom_range(99) < 80) begin
				add_req(ReqSeed, random_word());
				left--;
				run = $urandom_range(8, 1);
				while (run > 0 && left > 0) begin
					add_req(ReqMix, random_word());
					run--;
					left--;
				end
			end else begin
				add_req($urandom_range(1) ? ReqMix : ReqSeed, random_word());
				left--;
			end
		end
	endtask

	// Blocks until every queued request has gone in and every result beat has
	// come out, then lets the settle period pass. Sampling on the falling edge
	// keeps this clear of the updates made at the rising edge.
	task automatic wait_until_settled();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_states.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// One beat on the configuration channel. The shadow key follows at the
	// edge where the beat is taken.
	task automatic write_cfg_reg(srr_cfg_idx_t idx, srr_word_t data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == CfgKeyLow)
			model_key.lo = data;
		else if (idx == CfgKeyHigh)
			model_key.hi = data;
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------

	// A beat is taken at an edge where valid and ready are both high. At that
	// edge the driver records the expected state, then either presents the
	// next request or goes idle. A beat that is not taken is held unchanged.
	always @(posedge clk) begin : drive_requests
		rng_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_states.push_back(advance_rng_state(req_ch.req_type, req_ch.salt));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && (full_rate || $urandom_range(99) >= IdlePct)) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.req_type <= nxt.kind;
					req_ch.salt     <= nxt.salt;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------

	// Every result beat is matched against the oldest expectation, one word at
	// a time. Ready drops at random so that stalls land on every phase of the
	// core's two-stage pipeline, including the one where the request register
	// fills and request ready falls.
	always @(posedge clk) begin : check_results
		srr_state_t got;
		srr_state_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.word3, res_ch.word2, res_ch.word1, res_ch.word0};
				if (expected_states.size() == 0) begin
					report_mismatch($sformatf("result beat %h with no request outstanding",
						got));
				end else begin
					want = expected_states.pop_front();
					for (int i = 0; i < NumWords; i++) begin
						if (got[i] !== want[i])
							report_mismatch($sformatf("word%0d got %h expected %h",
								i, got[i], want[i]));
					end
				end
			end
			res_ch.ready <= full_rate || ($urandom_range(99) >= IdlePct);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin : run_test
		int unsigned ph;

		// Every input of the core holds a known value from time zero.
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = ReqSeed;
		req_ch.salt     = '0;
		res_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = CfgKeyLow;
		cfg_ch.data     = '0;
		model_key       = '0;
		model_state     = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. With the reset key of zero, a mix before any seed
		// runs on the all-zero state; a mix carrying salt must ignore it.
		add_req(ReqMix, '0);
		add_req(ReqSeed, '0);
		add_req(ReqMix, '0);
		add_req(ReqSeed, '1);
		add_req(ReqMix, '1);
		wait_until_settled();

		// All-ones key with the salt at its extremes.
		write_cfg_reg(CfgKeyLow, '1);
		write_cfg_reg(CfgKeyHigh, '1);
		add_req(ReqSeed, '0);
		add_req(ReqMix, '0);
		add_req(ReqSeed, 64'h8000000000000000);
		add_req(ReqMix, 64'h0000000000000001);
		wait_until_settled();

		write_cfg_reg(CfgKeyLow, 64'h0123456789abcdef);
		write_cfg_reg(CfgKeyHigh, 64'hfedcba9876543210);
		add_req(ReqSeed, 64'h5555555555555555);
		add_req(ReqMix, 64'haaaaaaaaaaaaaaaa);
		wait_until_settled();

		// Key changed after seeding: the following mixes take the new key.
		write_cfg_reg(CfgKeyLow, '0);
		write_cfg_reg(CfgKeyHigh, 64'ha5a5a5a5a5a5a5a5);
		add_req(ReqMix, '0);
		add_req(ReqMix, '0);
		wait_until_settled();

		// Writes to the unused indexes must not disturb either key word.
		write_cfg_reg(CfgSpareA, '1);
		write_cfg_reg(CfgSpareB, 64'h123456789abcdef0);
		add_req(ReqMix, '0);
		wait_until_settled();

		write_cfg_reg(CfgKeyHigh, '0);
		add_req(ReqMix, '0);
		add_req(ReqSeed, 64'haaaaaaaaaaaaaaaa);
		wait_until_settled();

		// Random part in phases, each with a fresh key. Halfway through every
		// phase the sender holds off until the core has drained. Phase four
		// runs with no idling on either side.
		for (ph = 0; ph < 9; ph++) begin
			write_cfg_reg(CfgKeyLow, random_word());
			write_cfg_reg(CfgKeyHigh, random_word());
			if ($urandom_range(2) == 0)
				write_cfg_reg(ph[0] ? CfgSpareB : CfgSpareA, random_word());
			full_rate = (ph == 4);
			queue_random_burst(63);
			wait_until_settled();
			queue_random_burst(63);
			wait_until_settled();
		end
		full_rate = 1'b0;

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule : siphash_round_rng_core_tb
`default_nettype wire
